// File: rtl/sbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

  localparam int ADDR_W      = 22;
  localparam int PIX_W       = 8;
  localparam int DIM_REG_W   = 12;
  localparam int CODE_REG_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Palette entries used by the overlay start at this index.
  localparam logic [PIX_W-1:0] PALETTE_BASE = 8'hD0;
  // In PGS pictures this pixel value is the transparent one.
  localparam logic [PIX_W-1:0] PGS_CLEAR_PIXEL = 8'd16;
  localparam logic [PIX_W-1:0] TRANSPARENT = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PICTURE_WIDTH   = 3'd0,
    REG_PICTURE_HEIGHT  = 3'd1,
    REG_BUFFER_WIDTH    = 3'd2,
    REG_BUFFER_HEIGHT   = 3'd3,
    REG_CONVERSION_MODE = 3'd4,
    REG_PLACE_TOP       = 3'd5,
    REG_CONTRAST_CODES  = 3'd6,
    REG_COLOR_CODES     = 3'd7
  } reg_index_t;

  // The last code is not a conversion; pixels still move the raster position.
  typedef enum logic [1:0] {
    MODE_COLOR  = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_PGS    = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0]  picture_width;
    logic [DIM_REG_W-1:0]  picture_height;
    logic [DIM_REG_W-1:0]  buffer_width;
    logic [DIM_REG_W-1:0]  buffer_height;
    logic [1:0]            conversion_mode;
    logic                  place_top;
    logic [CODE_REG_W-1:0] contrast_codes;
    logic [CODE_REG_W-1:0] color_codes;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/sbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Raster position tracking, crop test and palette mapping. Holds one
// visible pixel in its output register until the address stage takes it.
module sbp_front #(
  parameter int MAX_DIMENSION = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sbp_pkg::cfg_t              cfg,
  input  wire logic                       pixel_valid,
  output logic                            pixel_stall,
  input  wire logic [sbp_pkg::PIX_W-1:0]  pixel_value,
  input  wire logic                       picture_start,
  input  wire logic                       next_ready,
  output logic                            stage_valid,
  output logic [sbp_pkg::PIX_W-1:0]       stage_value,
  output logic                            stage_last,
  output logic [$clog2(MAX_DIMENSION+1)-1:0] stage_row,
  output logic [$clog2(MAX_DIMENSION+1)-1:0] stage_col,
  output logic [$clog2(MAX_DIMENSION+1)-1:0] buffer_width_eff
);

  localparam int DW = $clog2(MAX_DIMENSION + 1);

  function automatic logic [DW-1:0] clamp_dim(input logic [sbp_pkg::DIM_REG_W-1:0] v);
    clamp_dim = (32'(v) > 32'(MAX_DIMENSION)) ? DW'(MAX_DIMENSION) : DW'(v);
  endfunction

  logic [DW-1:0] column_count;
  logic [DW-1:0] row_count;
  logic [DW-1:0] column_count_next;
  logic [DW-1:0] row_count_next;

  logic [DW-1:0] pw, ph, bw, bh, vw, vh;
  logic [DW-1:0] col, row, col_inc, first_row, h_offset;
  logic [DW-1:0] row_index, col_addr;
  logic          active, visible, mode_ok, emit, accept, last;
  logic [1:0]    code;
  logic [3:0]    contrast, color;
  logic [sbp_pkg::PIX_W-1:0] value, shifted;

  always_comb begin
    pw = clamp_dim(cfg.picture_width);
    ph = clamp_dim(cfg.picture_height);
    bw = clamp_dim(cfg.buffer_width);
    bh = clamp_dim(cfg.buffer_height);
    vw = (pw < bw) ? pw : bw;
    vh = (ph < bh) ? ph : bh;

    // A new picture restarts the raster position on its first pixel.
    col = picture_start ? '0 : column_count;
    row = picture_start ? '0 : row_count;

    active  = (pw != '0) && (row < ph);
    visible = active && (row < vh) && (col < vw);

    col_inc = col + DW'(1);
    column_count_next = col;
    row_count_next    = row;
    if (active) begin
      if (col_inc >= pw) begin
        column_count_next = '0;
        row_count_next    = row + DW'(1);
      end else begin
        column_count_next = col_inc;
      end
    end

    code     = pixel_value[1:0];
    contrast = cfg.contrast_codes[{code, 2'b00} +: 4];
    color    = cfg.color_codes[{code, 2'b00} +: 4];
    shifted  = pixel_value + sbp_pkg::PALETTE_BASE;

    mode_ok = 1'b1;
    value   = sbp_pkg::TRANSPARENT;
    case (cfg.conversion_mode)
      sbp_pkg::MODE_COLOR: begin
        value = (contrast == 4'd0) ? sbp_pkg::TRANSPARENT
                                   : (sbp_pkg::PALETTE_BASE | {4'd0, color});
      end
      sbp_pkg::MODE_RAW: begin
        value = (contrast == 4'd0) ? sbp_pkg::PALETTE_BASE : shifted;
      end
      sbp_pkg::MODE_PGS: begin
        value = (pixel_value == sbp_pkg::PGS_CLEAR_PIXEL) ? sbp_pkg::TRANSPARENT : shifted;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    emit = visible && mode_ok;

    // Buffer row of this picture row; it stays below the buffer height.
    first_row = cfg.place_top ? '0 : (bh - vh);
    row_index = first_row + row;
    h_offset  = (bw - vw) >> 1;
    col_addr  = h_offset + col;
    last      = (row == (vh - DW'(1))) && (col == (vw - DW'(1)));
  end

  assign pixel_stall      = stage_valid && !next_ready;
  assign accept           = pixel_valid && !pixel_stall;
  assign buffer_width_eff = bw;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || next_ready) begin
      stage_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      stage_value <= value;
      stage_last  <= last;
      stage_row   <= row_index;
      stage_col   <= col_addr;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbp_addr.sv
`timescale 1ns / 1ps
`default_nettype none

// Forms the overlay byte address (buffer row times row length plus column)
// and holds the finished write in the output register.
module sbp_addr #(
  parameter int MAX_DIMENSION = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          stage_valid,
  output logic                               next_ready,
  input  wire logic [sbp_pkg::PIX_W-1:0]     stage_value,
  input  wire logic                          stage_last,
  input  wire logic [$clog2(MAX_DIMENSION+1)-1:0] stage_row,
  input  wire logic [$clog2(MAX_DIMENSION+1)-1:0] stage_col,
  input  wire logic [$clog2(MAX_DIMENSION+1)-1:0] buffer_width_eff,
  output logic                               write_valid,
  input  wire logic                          write_stall,
  output logic [sbp_pkg::ADDR_W-1:0]         write_address,
  output logic [sbp_pkg::PIX_W-1:0]          write_value,
  output logic                               last_write
);

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int PW = 2 * DW;
  localparam int AW = sbp_pkg::ADDR_W;

  logic [PW-1:0] product;
  logic [AW-1:0] address;

  always_comb begin
    product = PW'(stage_row) * PW'(buffer_width_eff);
    // The address wraps at the width of the write port.
    address = AW'(product) + AW'(stage_col);
  end

  assign next_ready = !write_valid || !write_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (next_ready) begin
      write_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (next_ready && stage_valid) begin
      write_address <= address;
      write_value   <= stage_value;
      last_write    <= stage_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/subtitle_bitmap_to_palette_blit_top.sv
// Subtitle picture to 8-bpp overlay blitter.
// The pixel channel (pixel_valid, pixel_stall, pixel_value, picture_start)
// carries one source pixel per transfer in raster order; picture_start is set
// on the first pixel of each picture and restarts the row and column count.
// For every pixel that lands inside the cropped, horizontally centered and
// top- or bottom-aligned window, the write channel (write_valid, write_stall,
// write_address, write_value, last_write) presents one byte write into the
// overlay buffer. Cropped pixels, pixels past the picture's end and pixels in
// unused mode produce no transfer. last_write marks the final visible pixel.
// Throughput is one pixel per clock while write_stall is low. A transferred
// pixel passes the register after the crop and palette mapping, then the one
// after the address multiply, before the write port presents its write.
// When the receiver asserts write_stall, the held write stays unchanged and
// the mapping register keeps one more pixel; pixel_stall rises only once both
// registers are full, so the sender is held back in that same cycle.
// Reset (synchronous, active high) empties both registers, clears the raster
// position and loads the register defaults: all dimensions 1, color mode,
// bottom alignment, all contrast and color codes zero. The user must write
// registers through config_write, config_index and config_data only while no
// write is pending; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module subtitle_bitmap_to_palette_blit_top #(
  parameter int MAX_DIMENSION = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             config_write,
  input  wire logic [sbp_pkg::CFG_INDEX_W-1:0]  config_index,
  input  wire logic [sbp_pkg::CFG_DATA_W-1:0]   config_data,
  input  wire logic                             pixel_valid,
  output logic                                  pixel_stall,
  input  wire logic [sbp_pkg::PIX_W-1:0]        pixel_value,
  input  wire logic                             picture_start,
  output logic                                  write_valid,
  input  wire logic                             write_stall,
  output logic [sbp_pkg::ADDR_W-1:0]            write_address,
  output logic [sbp_pkg::PIX_W-1:0]             write_value,
  output logic                                  last_write
);

  localparam int DW = $clog2(MAX_DIMENSION + 1);

  sbp_pkg::cfg_t cfg;

  logic          stage_valid;
  logic          next_ready;
  logic [sbp_pkg::PIX_W-1:0] stage_value;
  logic          stage_last;
  logic [DW-1:0] stage_row;
  logic [DW-1:0] stage_col;
  logic [DW-1:0] buffer_width_eff;

  // Register file. Values keep the width of their register; the upper
  // data bits of narrower registers are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.picture_width   <= sbp_pkg::DIM_REG_W'(1);
      cfg.picture_height  <= sbp_pkg::DIM_REG_W'(1);
      cfg.buffer_width    <= sbp_pkg::DIM_REG_W'(1);
      cfg.buffer_height   <= sbp_pkg::DIM_REG_W'(1);
      cfg.conversion_mode <= sbp_pkg::MODE_COLOR;
      cfg.place_top       <= 1'b0;
      cfg.contrast_codes  <= '0;
      cfg.color_codes     <= '0;
    end else if (config_write) begin
      case (sbp_pkg::reg_index_t'(config_index))
        sbp_pkg::REG_PICTURE_WIDTH:   cfg.picture_width   <= config_data[11:0];
        sbp_pkg::REG_PICTURE_HEIGHT:  cfg.picture_height  <= config_data[11:0];
        sbp_pkg::REG_BUFFER_WIDTH:    cfg.buffer_width    <= config_data[11:0];
        sbp_pkg::REG_BUFFER_HEIGHT:   cfg.buffer_height   <= config_data[11:0];
        sbp_pkg::REG_CONVERSION_MODE: cfg.conversion_mode <= config_data[1:0];
        sbp_pkg::REG_PLACE_TOP:       cfg.place_top       <= config_data[0];
        sbp_pkg::REG_CONTRAST_CODES:  cfg.contrast_codes  <= config_data;
        sbp_pkg::REG_COLOR_CODES:     cfg.color_codes     <= config_data;
        default: begin
        end
      endcase
    end
  end

  // Raster position, crop window and palette mapping.
  sbp_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .pixel_valid      (pixel_valid),
    .pixel_stall      (pixel_stall),
    .pixel_value      (pixel_value),
    .picture_start    (picture_start),
    .next_ready       (next_ready),
    .stage_valid      (stage_valid),
    .stage_value      (stage_value),
    .stage_last       (stage_last),
    .stage_row        (stage_row),
    .stage_col        (stage_col),
    .buffer_width_eff (buffer_width_eff)
  );

  // Address multiply and output register.
  sbp_addr #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_addr (
    .clk              (clk),
    .rst              (rst),
    .stage_valid      (stage_valid),
    .next_ready       (next_ready),
    .stage_value      (stage_value),
    .stage_last       (stage_last),
    .stage_row        (stage_row),
    .stage_col        (stage_col),
    .buffer_width_eff (buffer_width_eff),
    .write_valid      (write_valid),
    .write_stall      (write_stall),
    .write_address    (write_address),
    .write_value      (write_value),
    .last_write       (last_write)
  );

endmodule

`default_nettype wire

// File: rtl/sbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sbp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        pixel_valid,
  input wire logic                        pixel_stall,
  input wire logic                        write_valid,
  input wire logic                        write_stall,
  input wire logic [sbp_pkg::ADDR_W-1:0]  write_address,
  input wire logic [sbp_pkg::PIX_W-1:0]   write_value,
  input wire logic                        last_write
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !write_valid)
    else $error("write_valid high after reset");

  // A held write stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    write_valid && write_stall |=> write_valid && $stable(write_address)
      && $stable(write_value) && $stable(last_write))
    else $error("stalled write changed");

  // The sender is only held back when the receiver is holding a write.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> write_valid && write_stall)
    else $error("pixel_stall without a stalled write");

  // A write that appears in an empty output register came from a pixel accepted
  // into the mapping register, which passed it straight on to the output register.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(write_valid) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("write without a matching pixel transfer");

endmodule

bind subtitle_bitmap_to_palette_blit_top sbp_checker u_sbp_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_valid   (pixel_valid),
  .pixel_stall   (pixel_stall),
  .write_valid   (write_valid),
  .write_stall   (write_stall),
  .write_address (write_address),
  .write_value   (write_value),
  .last_write    (last_write)
);

`default_nettype wire
